// ===== rtl/delta_address_symbol_resolver_assert.svh =====
`ifndef DELTA_ADDRESS_SYMBOL_RESOLVER_ASSERT_SVH
`define DELTA_ADDRESS_SYMBOL_RESOLVER_ASSERT_SVH

// property checked on every clock edge outside reset
`define DASR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define DASR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/dasr_pkg.sv =====
`timescale 1ns / 1ps
package dasr_pkg;

  localparam int START_W = 64;
  localparam int ID_W    = 16;
  localparam int ENTRY_W = START_W + ID_W;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_CHAR = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  localparam logic [1:0] KIND_SYMBOL = 2'd0;
  localparam logic [1:0] KIND_RAW    = 2'd1;
  localparam logic [1:0] KIND_EOL    = 2'd2;

  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_UNDER = 8'h5f;

  localparam logic [2:0] PREFIX_LEN = 3'd5;

  typedef struct packed {
    logic               done;
    logic               found;
    logic [START_W-1:0] best_start;
    logic [ID_W-1:0]    best_id;
  } scan_res_t;

  // expected character at each prefix position
  function automatic logic [7:0] guest_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = 8'h47;
      3'd1: c = 8'h55;
      3'd2: c = 8'h45;
      3'd3: c = 8'h53;
      3'd4: c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // bit 4 set when the character is a hex digit, low nibble its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b1, 4'(c - 8'h37)};
    end
    return v;
  endfunction

endpackage

// ===== rtl/dasr_ram.sv =====
`timescale 1ns / 1ps
module dasr_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/dasr_scan.sv =====
`timescale 1ns / 1ps
module dasr_scan #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [dasr_pkg::START_W-1:0]     addr,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
  output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
  input  logic [dasr_pkg::ENTRY_W-1:0]     rd_data,
  output dasr_pkg::scan_res_t              res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic                         busy;
  logic [CW-1:0]                issue_cnt;
  logic                         rd_pending;
  logic                         found;
  logic [dasr_pkg::START_W-1:0] best_start;
  logic [dasr_pkg::ID_W-1:0]    best_id;
  logic                         done;
  logic [dasr_pkg::START_W-1:0] entry_start;
  logic                         hit;

  assign rd_addr     = issue_cnt[AW-1:0];
  assign entry_start = rd_data[dasr_pkg::ENTRY_W-1:dasr_pkg::ID_W];
  // strictly greater keeps the earliest entry on equal starts
  assign hit = (entry_start <= addr) && (!found || entry_start > best_start);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      issue_cnt  <= '0;
      rd_pending <= 1'b0;
      found      <= 1'b0;
      done       <= 1'b0;
    end else begin
      done       <= 1'b0;
      rd_pending <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        issue_cnt <= '0;
        found     <= 1'b0;
      end else if (busy) begin
        if (issue_cnt != count) begin
          issue_cnt  <= issue_cnt + CW'(1);
          rd_pending <= 1'b1;
        end else if (!rd_pending) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        if (rd_pending && hit) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && rd_pending && hit) begin
      best_start <= entry_start;
      best_id    <= rd_data[dasr_pkg::ID_W-1:0];
    end
  end

  assign res.done       = done;
  assign res.found      = found;
  assign res.best_start = best_start;
  assign res.best_id    = best_id;

endmodule

// ===== rtl/delta_address_symbol_resolver.sv =====
// load and plain character words: no result
// word that gives an address: table scan, difference state, then the result word;
// one table entry read per cycle through the memory read port
// end of token adds the end-of-line word after it; only that word when inactive
// synchronous reset clears table count and token state, sets the limit to 1048576;
// memory is not cleared
`timescale 1ns / 1ps
`include "delta_address_symbol_resolver_assert.svh"
module delta_address_symbol_resolver #(
  parameter int TABLE_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [63:0] sym_start,
  input  logic [15:0] sym_id,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] symbol_id,
  output logic [31:0] offset,
  output logic [63:0] address,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DIFF = 3'd2;
  localparam logic [2:0] ST_ADDR = 3'd3;
  localparam logic [2:0] ST_EOL  = 3'd4;

  logic [2:0]  state;
  logic [CW-1:0] sym_count;
  logic [31:0] proximity_limit;
  logic [63:0] delta_accum;
  logic [63:0] running_address;
  logic        minus_sign;
  logic [2:0]  prefix_position;
  logic        prefix_ok;
  logic [63:0] scan_addr;
  logic [63:0] diff;
  logic        eol_pending;

  logic        accept;
  logic        token_active;
  logic [63:0] applied;
  logic [4:0]  hex;
  logic        is_sign;
  logic        scan_start;
  logic        out_free;
  logic        sym_hit;
  logic        wr_en;

  logic [AW-1:0]                 rd_addr;
  logic [dasr_pkg::ENTRY_W-1:0]  rd_data;
  dasr_pkg::scan_res_t           scan_res;

  assign in_ready     = (state == ST_IDLE);
  assign accept       = in_valid && in_ready;
  assign cfg_ready    = 1'b1;
  assign token_active = prefix_ok && (prefix_position >= dasr_pkg::PREFIX_LEN);
  assign applied      = minus_sign ? running_address - delta_accum
                                   : running_address + delta_accum;
  assign hex          = dasr_pkg::hex_value(char_code);
  assign is_sign      = (char_code == dasr_pkg::CHAR_PLUS) ||
                        (char_code == dasr_pkg::CHAR_MINUS);
  assign scan_start   = accept && token_active &&
                        ((cmd == dasr_pkg::CMD_CHAR && is_sign) || cmd == dasr_pkg::CMD_END);
  assign out_free     = !out_valid || out_ready;
  assign sym_hit      = scan_res.found && (diff[63:32] == 32'd0) &&
                        (diff[31:0] <= proximity_limit);
  assign wr_en        = accept && (cmd == dasr_pkg::CMD_LOAD) &&
                        (sym_count < CW'(TABLE_DEPTH));

  dasr_ram #(
    .WIDTH(dasr_pkg::ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(sym_count[AW-1:0]),
    .wr_data({sym_start, sym_id}),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  dasr_scan #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .addr   (scan_addr),
    .count  (sym_count),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .res    (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      proximity_limit <= 32'd1048576;
    end else if (cfg_valid) begin
      proximity_limit <= cfg_data;
    end
  end

  // token parser and table fill
  always_ff @(posedge clk) begin
    if (rst) begin
      sym_count       <= '0;
      delta_accum     <= '0;
      running_address <= '0;
      minus_sign      <= 1'b0;
      prefix_position <= '0;
      prefix_ok       <= 1'b1;
    end else if (accept) begin
      case (cmd)
        dasr_pkg::CMD_LOAD: begin
          if (wr_en) begin
            sym_count <= sym_count + CW'(1);
          end
        end
        dasr_pkg::CMD_CHAR: begin
          if (!token_active) begin
            if (prefix_position < dasr_pkg::PREFIX_LEN) begin
              if (char_code != dasr_pkg::guest_char(prefix_position)) begin
                prefix_ok <= 1'b0;
              end
              prefix_position <= prefix_position + 3'd1;
            end
          end else if (is_sign) begin
            running_address <= applied;
            delta_accum     <= '0;
            minus_sign      <= (char_code == dasr_pkg::CHAR_MINUS);
          end else if (char_code == dasr_pkg::CHAR_UNDER) begin
            minus_sign <= 1'b0;
          end else if (hex[4]) begin
            delta_accum <= {delta_accum[59:0], hex[3:0]};
          end
        end
        dasr_pkg::CMD_END: begin
          delta_accum     <= '0;
          running_address <= '0;
          minus_sign      <= 1'b0;
          prefix_position <= '0;
          prefix_ok       <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      eol_pending <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && cmd == dasr_pkg::CMD_END) begin
            eol_pending <= 1'b1;
            state       <= token_active ? ST_SCAN : ST_EOL;
          end else if (scan_start) begin
            eol_pending <= 1'b0;
            state       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_res.done) begin
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          state <= ST_ADDR;
        end
        ST_ADDR: begin
          if (out_free) begin
            state <= eol_pending ? ST_EOL : ST_IDLE;
          end
        end
        ST_EOL: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      scan_addr <= applied;
    end
    if (state == ST_DIFF) begin
      diff <= scan_addr - scan_res.best_start;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_ADDR && out_free) begin
      out_valid <= 1'b1;
    end else if (state == ST_EOL && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ADDR && out_free) begin
      kind      <= sym_hit ? dasr_pkg::KIND_SYMBOL : dasr_pkg::KIND_RAW;
      symbol_id <= sym_hit ? scan_res.best_id : 16'd0;
      offset    <= sym_hit ? diff[31:0] : 32'd0;
      address   <= scan_addr;
      last      <= !eol_pending;
    end else if (state == ST_EOL && out_free) begin
      kind      <= dasr_pkg::KIND_EOL;
      symbol_id <= 16'd0;
      offset    <= 32'd0;
      address   <= 64'd0;
      last      <= 1'b1;
    end
  end

  `DASR_ASSERT(a_done_in_scan, scan_res.done |-> state == ST_SCAN,
               "scan finished outside scan state")
  `DASR_NEVER(a_count_range, sym_count > CW'(TABLE_DEPTH),
              "symbol count beyond table depth")
  `DASR_ASSERT(a_sym_offset,
               (out_valid && kind == dasr_pkg::KIND_SYMBOL) |-> offset <= proximity_limit,
               "symbol offset above limit")
  `DASR_ASSERT(a_eol_last, (out_valid && kind == dasr_pkg::KIND_EOL) |-> last,
               "end of line word not marked last")

endmodule
